FILE: sv/mns_pkg.sv
// ----------------------------------------------------------------------------
// mns_pkg: shared types, constants and fixed-point helpers
// Widths, store layout, register codes and Q16.16 rounding/saturation for the
// modal Newmark-beta step block.
// ----------------------------------------------------------------------------
`default_nettype none

package mns_pkg;

  localparam int NUM_MODES = 64;
  localparam int MODE_AW   = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int IDX_W     = 6;
  localparam int DW        = 32;
  localparam int CW        = 31;
  localparam int STATE_W   = 5 * DW;
  localparam int DIV_STG   = 32;
  localparam int CFG_AW    = 3;
  localparam int Q_DEPTH   = 4;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  localparam logic signed [DW-1:0] Q_ONE  = 32'sd65536;
  localparam logic signed [63:0]   Q_HALF = 64'sd32768;

  typedef enum logic [CFG_AW-1:0] {
    REG_TIME_STEP  = 3'd0,
    REG_BETA_DT_SQ = 3'd1,
    REG_GAMMA_DT   = 3'd2,
    REG_PRED_DISP  = 3'd3,
    REG_PRED_VEL   = 3'd4,
    REG_MASS_DAMP  = 3'd5,
    REG_STIFF_DAMP = 3'd6
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic [CW-1:0] dt;
    logic [CW-1:0] bdt2;
    logic [CW-1:0] gdt;
    logic [CW-1:0] pdac;
    logic [CW-1:0] pvac;
    logic [CW-1:0] mdamp;
    logic [CW-1:0] sdamp;
  } coef_t;

  typedef struct packed {
    logic                 step;
    logic                 rng;
    logic [IDX_W-1:0]     idx;
    logic [CW-1:0]        w;
    logic signed [DW-1:0] f;
  } item_t;

  typedef struct packed {
    logic                 step;
    logic                 rng;
    logic [IDX_W-1:0]     idx;
    logic signed [DW-1:0] dp;
    logic signed [DW-1:0] vp;
    logic signed [DW-1:0] f;
    logic [CW-1:0]        w;
  } side_t;

  typedef struct packed {
    logic          vld;
    side_t         side;
    logic          neg;
    logic [DW-1:0] mag;
    logic [CW-1:0] dvs;
  } div_in_t;

  typedef struct packed {
    logic                 vld;
    side_t                side;
    logic signed [DW-1:0] an;
  } div_out_t;

  function automatic logic signed [DW-1:0] sat32(input logic signed [47:0] x);
    if (x > 48'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -48'sd2147483648) return 32'sh80000000;
    return $signed(x[DW-1:0]);
  endfunction

  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + Q_HALF;
    return sat32($signed(t[63:16]));
  endfunction

  function automatic logic signed [63:0] mul(input logic signed [DW-1:0] a,
                                             input logic signed [DW-1:0] b);
    logic signed [63:0] x;
    logic signed [63:0] y;
    x = 64'(a);
    y = 64'(b);
    return x * y;
  endfunction

endpackage

`default_nettype wire

FILE: sv/mns_ram.sv
// ----------------------------------------------------------------------------
// mns_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                          wr_data,
  input  wire logic                                      rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mns_front.sv
// ----------------------------------------------------------------------------
// mns_front: input acceptance and issue queue
// Classify each input word (load or step, index in range) and hold it in a
// short queue until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mns_front (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_mode,
  input  wire logic [mns_pkg::IDX_W-1:0]           in_mode_index,
  input  wire logic [mns_pkg::CW-1:0]              in_omega_sq,
  input  wire logic signed [mns_pkg::DW-1:0]       in_modal_force,
  output logic                                     q_vld,
  output mns_pkg::item_t                           q_item,
  input  wire logic                                q_pop
);

  mns_pkg::item_t              ent_r [mns_pkg::Q_DEPTH];
  mns_pkg::item_t              new_item;
  logic [mns_pkg::Q_AW-1:0]    wp_r;
  logic [mns_pkg::Q_AW-1:0]    rp_r;
  logic [mns_pkg::Q_AW:0]      cnt_r;
  logic [mns_pkg::Q_AW:0]      cnt_nxt;
  logic                        push;
  logic                        pop;

  assign in_stall = (cnt_r == (mns_pkg::Q_AW + 1)'(mns_pkg::Q_DEPTH));
  assign q_vld    = (cnt_r != '0);
  assign q_item   = ent_r[rp_r];
  assign push     = in_valid & ~in_stall;
  assign pop      = q_pop & q_vld;

  always_comb begin
    new_item.step = (in_mode == mns_pkg::OP_STEP);
    new_item.rng  = (32'(in_mode_index) < 32'(mns_pkg::NUM_MODES));
    new_item.idx  = in_mode_index;
    new_item.w    = in_omega_sq;
    new_item.f    = in_modal_force;
    cnt_nxt       = cnt_r + (mns_pkg::Q_AW + 1)'(push) - (mns_pkg::Q_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mns_div.sv
// ----------------------------------------------------------------------------
// mns_div: pipelined restoring divider
// One quotient bit per stage, signed result truncated toward zero; carries
// the item's side payload alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module mns_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire mns_pkg::div_in_t  din,
  output mns_pkg::div_out_t      dout
);

  typedef struct packed {
    logic                  vld;
    mns_pkg::side_t        side;
    logic                  neg;
    logic [mns_pkg::CW-1:0] r;
    logic [mns_pkg::DW-1:0] n;
    logic [mns_pkg::DW-1:0] q;
    logic [mns_pkg::CW-1:0] dvs;
  } dstg_t;

  dstg_t stg_r   [mns_pkg::DIV_STG];
  dstg_t stg_in  [mns_pkg::DIV_STG];
  dstg_t stg_nxt [mns_pkg::DIV_STG];
  dstg_t last;

  always_comb begin
    stg_in[0].vld  = din.vld;
    stg_in[0].side = din.side;
    stg_in[0].neg  = din.neg;
    stg_in[0].r    = mns_pkg::CW'(din.mag[mns_pkg::DW-1:16]);
    stg_in[0].n    = {din.mag[15:0], 16'h0000};
    stg_in[0].q    = '0;
    stg_in[0].dvs  = din.dvs;
    for (int k = 1; k < mns_pkg::DIV_STG; k++) begin
      stg_in[k] = stg_r[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < mns_pkg::DIV_STG; k++) begin
      logic [mns_pkg::DW-1:0] rs;
      logic                   ge;
      rs = {stg_in[k].r, stg_in[k].n[mns_pkg::DW-1]};
      ge = (rs >= {1'b0, stg_in[k].dvs});
      stg_nxt[k]   = stg_in[k];
      stg_nxt[k].r = ge ? mns_pkg::CW'(rs - {1'b0, stg_in[k].dvs}) : rs[mns_pkg::CW-1:0];
      stg_nxt[k].n = {stg_in[k].n[mns_pkg::DW-2:0], 1'b0};
      stg_nxt[k].q = {stg_in[k].q[mns_pkg::DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mns_pkg::DIV_STG; k++) begin
      if (!rst_n) begin
        stg_r[k].vld <= 1'b0;
      end else if (en) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign last = stg_r[mns_pkg::DIV_STG-1];

  always_comb begin
    dout.vld  = last.vld;
    dout.side = last.side;
    dout.an   = last.neg ? $signed(~last.q + 1'b1) : $signed(last.q);
  end

endmodule

`default_nettype wire

FILE: sv/mns_back.sv
// ----------------------------------------------------------------------------
// mns_back: issue, state store and Newmark datapath
// Issue queued words when their mode is not in flight, read the mode state,
// predict, solve, correct, write back and register the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module mns_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mns_pkg::coef_t                coef,
  input  wire logic                          q_vld,
  input  wire mns_pkg::item_t                q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mns_pkg::IDX_W-1:0]          out_mode_index_out,
  output logic signed [mns_pkg::DW-1:0]      out_displacement,
  output logic signed [mns_pkg::DW-1:0]      out_velocity,
  output logic signed [mns_pkg::DW-1:0]      out_acceleration
);

  localparam int AW = mns_pkg::MODE_AW;
  localparam int DW = mns_pkg::DW;
  localparam int CW = mns_pkg::CW;

  typedef struct packed {
    logic                 vld;
    logic                 step;
    logic                 rng;
    logic [mns_pkg::IDX_W-1:0] idx;
    logic                 ok;
    logic [CW-1:0]        w;
    logic signed [DW-1:0] f;
  } s0_t;

  typedef struct packed {
    logic                 vld;
    logic                 step;
    logic                 rng;
    logic [mns_pkg::IDX_W-1:0] idx;
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] v;
    logic signed [DW-1:0] f;
    logic [CW-1:0]        w;
    logic signed [63:0]   p_xw;
    logic signed [63:0]   p_dv;
    logic signed [63:0]   p_da;
    logic signed [63:0]   p_va;
    logic signed [63:0]   p_bw;
  } s1_t;

  typedef struct packed {
    logic                 vld;
    mns_pkg::side_t       side;
    logic signed [DW-1:0] xi;
    logic signed [DW-1:0] bw;
  } s2_t;

  typedef struct packed {
    logic                 vld;
    mns_pkg::side_t       side;
    logic signed [DW-1:0] bw;
    logic signed [63:0]   p_xv;
    logic signed [63:0]   p_wd;
    logic signed [63:0]   p_gx;
  } s3_t;

  typedef struct packed {
    logic                 vld;
    mns_pkg::side_t       side;
    logic signed [DW-1:0] an;
    logic signed [63:0]   p_ga;
    logic signed [63:0]   p_ba;
  } s5_t;

  s0_t s0_r, s0_nxt;
  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  mns_pkg::div_in_t  s4_r, s4_nxt;
  mns_pkg::div_out_t dq;
  s5_t s5_r, s5_nxt;

  logic [mns_pkg::NUM_MODES-1:0] pend_r, pend_nxt;
  logic [mns_pkg::NUM_MODES-1:0] ok_r, ok_nxt;

  logic                          adv;
  logic                          iss;
  logic                          wb;
  logic [AW-1:0]                 iss_addr;
  logic [AW-1:0]                 wb_addr;
  logic [AW+mns_pkg::IDX_W-1:0]  iss_ext;
  logic [AW+mns_pkg::IDX_W-1:0]  wb_ext;
  logic [mns_pkg::STATE_W-1:0]   rd_data;
  logic [mns_pkg::STATE_W-1:0]   wr_data;

  logic signed [DW-1:0] c_dt, c_bdt2, c_gdt, c_pdac, c_pvac, c_md, c_sd;
  logic signed [DW-1:0] m_d, m_v, m_a, m_f, m_w;
  logic signed [DW-1:0] a0, f0, rhs, lhs, d_fin, v_fin, a_fin;
  logic [CW-1:0]        w0;

  logic                           out_vld_r;
  logic [mns_pkg::IDX_W-1:0]      out_idx_r;
  logic signed [DW-1:0]           out_d_r, out_v_r, out_a_r;

  assign adv       = ~(out_vld_r & out_stall);
  assign iss_ext   = {{AW{1'b0}}, q_item.idx};
  assign iss_addr  = iss_ext[AW-1:0];
  assign wb_ext    = {{AW{1'b0}}, s5_r.side.idx};
  assign wb_addr   = wb_ext[AW-1:0];
  assign iss       = adv & q_vld & ~(q_item.rng & pend_r[iss_addr]);
  assign q_pop     = iss;
  assign wb        = adv & s5_r.vld & s5_r.side.rng;

  assign c_dt   = $signed({1'b0, coef.dt});
  assign c_bdt2 = $signed({1'b0, coef.bdt2});
  assign c_gdt  = $signed({1'b0, coef.gdt});
  assign c_pdac = $signed({1'b0, coef.pdac});
  assign c_pvac = $signed({1'b0, coef.pvac});
  assign c_md   = $signed({1'b0, coef.mdamp});
  assign c_sd   = $signed({1'b0, coef.sdamp});

  mns_ram #(
    .WIDTH (mns_pkg::STATE_W),
    .DEPTH (mns_pkg::NUM_MODES)
  ) u_state (
    .clk     (clk),
    .wr_en   (wb),
    .wr_addr (wb_addr),
    .wr_data (wr_data),
    .rd_en   (iss),
    .rd_addr (iss_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    s0_nxt.vld  = iss;
    s0_nxt.step = q_item.step;
    s0_nxt.rng  = q_item.rng;
    s0_nxt.idx  = q_item.idx;
    s0_nxt.ok   = ok_r[iss_addr];
    s0_nxt.w    = q_item.w;
    s0_nxt.f    = q_item.f;
  end

  always_comb begin
    m_d = s0_r.ok ? $signed(rd_data[5*DW-1:4*DW]) : '0;
    m_v = s0_r.ok ? $signed(rd_data[4*DW-1:3*DW]) : '0;
    m_a = s0_r.ok ? $signed(rd_data[3*DW-1:2*DW]) : '0;
    m_f = s0_r.ok ? $signed(rd_data[2*DW-1:DW])   : '0;
    m_w = s0_r.ok ? $signed(rd_data[DW-1:0])      : '0;
    a0  = s0_r.step ? m_a : s0_r.f;
    f0  = s0_r.step ? m_f : s0_r.f;
    w0  = s0_r.step ? m_w[CW-1:0] : s0_r.w;
    s1_nxt.vld  = s0_r.vld;
    s1_nxt.step = s0_r.step;
    s1_nxt.rng  = s0_r.rng;
    s1_nxt.idx  = s0_r.idx;
    s1_nxt.d    = m_d;
    s1_nxt.v    = m_v;
    s1_nxt.f    = f0;
    s1_nxt.w    = w0;
    s1_nxt.p_xw = mns_pkg::mul(c_sd, $signed({1'b0, w0}));
    s1_nxt.p_dv = mns_pkg::mul(c_dt, m_v);
    s1_nxt.p_da = mns_pkg::mul(c_pdac, a0);
    s1_nxt.p_va = mns_pkg::mul(c_pvac, a0);
    s1_nxt.p_bw = mns_pkg::mul(c_bdt2, $signed({1'b0, w0}));
  end

  always_comb begin
    s2_nxt.vld       = s1_r.vld;
    s2_nxt.side.step = s1_r.step;
    s2_nxt.side.rng  = s1_r.rng;
    s2_nxt.side.idx  = s1_r.idx;
    s2_nxt.side.f    = s1_r.f;
    s2_nxt.side.w    = s1_r.w;
    if (s1_r.step) begin
      s2_nxt.side.dp = mns_pkg::sat32(48'(s1_r.d) + 48'(mns_pkg::rnd_sat(s1_r.p_dv))
                                      + 48'(mns_pkg::rnd_sat(s1_r.p_da)));
      s2_nxt.side.vp = mns_pkg::sat32(48'(s1_r.v) + 48'(mns_pkg::rnd_sat(s1_r.p_va)));
    end else begin
      s2_nxt.side.dp = s1_r.d;
      s2_nxt.side.vp = s1_r.v;
    end
    s2_nxt.xi = mns_pkg::sat32(48'(c_md) + 48'(mns_pkg::rnd_sat(s1_r.p_xw)));
    s2_nxt.bw = mns_pkg::rnd_sat(s1_r.p_bw);
  end

  always_comb begin
    s3_nxt.vld  = s2_r.vld;
    s3_nxt.side = s2_r.side;
    s3_nxt.bw   = s2_r.bw;
    s3_nxt.p_xv = mns_pkg::mul(s2_r.xi, s2_r.side.vp);
    s3_nxt.p_wd = mns_pkg::mul($signed({1'b0, s2_r.side.w}), s2_r.side.dp);
    s3_nxt.p_gx = mns_pkg::mul(c_gdt, s2_r.xi);
  end

  always_comb begin
    rhs = mns_pkg::sat32(48'(s3_r.side.f) - 48'(mns_pkg::rnd_sat(s3_r.p_xv))
                         - 48'(mns_pkg::rnd_sat(s3_r.p_wd)));
    lhs = mns_pkg::sat32(48'(mns_pkg::Q_ONE) + 48'(mns_pkg::rnd_sat(s3_r.p_gx))
                         + 48'(s3_r.bw));
    s4_nxt.vld  = s3_r.vld;
    s4_nxt.side = s3_r.side;
    s4_nxt.neg  = rhs[DW-1];
    s4_nxt.mag  = rhs[DW-1] ? (~rhs + 1'b1) : rhs;
    s4_nxt.dvs  = lhs[CW-1:0];
  end

  mns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .din   (s4_r),
    .dout  (dq)
  );

  always_comb begin
    s5_nxt.vld  = dq.vld;
    s5_nxt.side = dq.side;
    s5_nxt.an   = dq.an;
    s5_nxt.p_ga = mns_pkg::mul(c_gdt, dq.an);
    s5_nxt.p_ba = mns_pkg::mul(c_bdt2, dq.an);
  end

  always_comb begin
    if (!s5_r.side.rng) begin
      d_fin = '0;
      v_fin = '0;
      a_fin = '0;
    end else if (s5_r.side.step) begin
      d_fin = mns_pkg::sat32(48'(s5_r.side.dp) + 48'(mns_pkg::rnd_sat(s5_r.p_ba)));
      v_fin = mns_pkg::sat32(48'(s5_r.side.vp) + 48'(mns_pkg::rnd_sat(s5_r.p_ga)));
      a_fin = s5_r.an;
    end else begin
      d_fin = s5_r.side.dp;
      v_fin = s5_r.side.vp;
      a_fin = s5_r.side.f;
    end
    wr_data = {d_fin, v_fin, a_fin, s5_r.side.f, {1'b0, s5_r.side.w}};
  end

  always_comb begin
    pend_nxt = pend_r;
    ok_nxt   = ok_r;
    if (wb) begin
      pend_nxt[wb_addr] = 1'b0;
      ok_nxt[wb_addr]   = 1'b1;
    end
    if (iss & q_item.rng) begin
      pend_nxt[iss_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r    <= '0;
      ok_r      <= '0;
      s0_r.vld  <= 1'b0;
      s1_r.vld  <= 1'b0;
      s2_r.vld  <= 1'b0;
      s3_r.vld  <= 1'b0;
      s4_r.vld  <= 1'b0;
      s5_r.vld  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      ok_r   <= ok_nxt;
      if (adv) begin
        s0_r      <= s0_nxt;
        s1_r      <= s1_nxt;
        s2_r      <= s2_nxt;
        s3_r      <= s3_nxt;
        s4_r      <= s4_nxt;
        s5_r      <= s5_nxt;
        out_vld_r <= s5_r.vld;
        out_idx_r <= s5_r.side.idx;
        out_d_r   <= d_fin;
        out_v_r   <= v_fin;
        out_a_r   <= a_fin;
      end
    end
  end

  assign out_valid          = out_vld_r;
  assign out_mode_index_out = out_idx_r;
  assign out_displacement   = out_d_r;
  assign out_velocity       = out_v_r;
  assign out_acceleration   = out_a_r;

  a_wb_pending: assert property (@(posedge clk) disable iff (!rst_n)
    wb |-> pend_r[wb_addr])
    else $error("writeback to a mode with no word in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (iss && q_item.rng && wb) |-> (iss_addr != wb_addr))
    else $error("issue and writeback hit the same mode");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_stall) |=>
      ($stable(s5_r.vld) && $stable(pend_r) && $stable(out_idx_r)))
    else $error("pipeline moved while result was stalled");

endmodule

`default_nettype wire

FILE: sv/modal_newmark_step.sv
// ----------------------------------------------------------------------------
// modal_newmark_step: Newmark-beta time step over 64 decoupled modes
// Input words (in_valid/in_stall) either load a mode's squared frequency and
// force, or advance that mode one step; every word yields one result word
// (out_valid/out_stall) with the mode's displacement, velocity, acceleration.
// Coefficients are written on cfg_valid/cfg_ready/cfg_index/cfg_wdata; the
// user must write them only while the block is idle, and the block itself does
// not enforce it; cfg_ready is always high, unknown indexes are dropped.
// Throughput: one word per cycle while the output is not stalled and no word
// addresses a mode that still has a word in flight. The datapath holds a
// 32-stage one-bit-per-stage divider plus the multiply stages around it.
// A word whose mode still has a word in flight waits in the 4-entry queue
// until that word writes its state back.
// Reset clears the coefficients, the queue, the pipeline and per-mode valid
// bits, so all modes read as zero; no clearing pass is needed.
// When out_stall is high while out_valid is high the whole back end holds; the
// queue keeps accepting until full, then in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module modal_newmark_step (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_mode,
  input  wire logic [mns_pkg::IDX_W-1:0]         in_mode_index,
  input  wire logic [mns_pkg::CW-1:0]            in_omega_sq,
  input  wire logic signed [mns_pkg::DW-1:0]     in_modal_force,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [mns_pkg::IDX_W-1:0]              out_mode_index_out,
  output logic signed [mns_pkg::DW-1:0]          out_displacement,
  output logic signed [mns_pkg::DW-1:0]          out_velocity,
  output logic signed [mns_pkg::DW-1:0]          out_acceleration,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mns_pkg::CFG_AW-1:0]        cfg_index,
  input  wire logic [mns_pkg::DW-1:0]            cfg_wdata
);

  mns_pkg::coef_t coef_r;
  mns_pkg::item_t q_item;
  logic           q_vld;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (mns_pkg::cfg_reg_t'(cfg_index))
        mns_pkg::REG_TIME_STEP:  coef_r.dt    <= cfg_wdata[mns_pkg::CW-1:0];
        mns_pkg::REG_BETA_DT_SQ: coef_r.bdt2  <= cfg_wdata[mns_pkg::CW-1:0];
        mns_pkg::REG_GAMMA_DT:   coef_r.gdt   <= cfg_wdata[mns_pkg::CW-1:0];
        mns_pkg::REG_PRED_DISP:  coef_r.pdac  <= cfg_wdata[mns_pkg::CW-1:0];
        mns_pkg::REG_PRED_VEL:   coef_r.pvac  <= cfg_wdata[mns_pkg::CW-1:0];
        mns_pkg::REG_MASS_DAMP:  coef_r.mdamp <= cfg_wdata[mns_pkg::CW-1:0];
        mns_pkg::REG_STIFF_DAMP: coef_r.sdamp <= cfg_wdata[mns_pkg::CW-1:0];
        default: begin
          coef_r <= coef_r;
        end
      endcase
    end
  end

  mns_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_mode_index  (in_mode_index),
    .in_omega_sq    (in_omega_sq),
    .in_modal_force (in_modal_force),
    .q_vld          (q_vld),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  mns_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .coef               (coef_r),
    .q_vld              (q_vld),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_mode_index_out (out_mode_index_out),
    .out_displacement   (out_displacement),
    .out_velocity       (out_velocity),
    .out_acceleration   (out_acceleration)
  );

endmodule

`default_nettype wire

FILE: test/modal_newmark_step_test.sv
// ----------------------------------------------------------------------------
// modal_newmark_step_test: self-checking bench for the modal Newmark-beta step
// Drives load and step words at random burst and stall patterns through
// several coefficient sets, predicts each result in Q16.16 arithmetic and
// compares it field by field with the block's output words.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module modal_newmark_step_test;

  class newmark_scoreboard;
    logic [mns_pkg::CW-1:0] coef [7];
    logic signed [63:0] disp [64], vel [64], accel [64], force_q [64], wsq [64];
    logic [mns_pkg::IDX_W-1:0] exp_idx [$];
    logic signed [mns_pkg::DW-1:0] exp_d [$], exp_v [$], exp_a [$];
    int errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      for (int i = 0; i < 64; i++) begin
        disp[i] = 0; vel[i] = 0; accel[i] = 0; force_q[i] = 0; wsq[i] = 0;
      end
      errors = 0;
    endfunction

    function void set_coef(int idx, logic [mns_pkg::DW-1:0] val);
      if (idx < 7) coef[idx] = val[mns_pkg::CW-1:0];
    endfunction

    function logic signed [63:0] clip(logic signed [63:0] x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function logic signed [63:0] qprod(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] q;
      q = a * b + 64'sd32768;
      return clip(q >>> 16);
    endfunction

    function void note_input(logic op, logic [mns_pkg::IDX_W-1:0] idx,
                             logic [mns_pkg::CW-1:0] w,
                             logic signed [mns_pkg::DW-1:0] f);
      logic signed [63:0] d, v, a, xi, dp, vp, rhs, lhs, an;
      if (op == mns_pkg::OP_LOAD) begin
        wsq[idx] = {33'd0, w};
        force_q[idx] = f;
        accel[idx] = f;
      end else begin
        d = disp[idx]; v = vel[idx]; a = accel[idx];
        xi = clip({33'd0, coef[mns_pkg::REG_MASS_DAMP]}
                  + qprod({33'd0, coef[mns_pkg::REG_STIFF_DAMP]}, wsq[idx]));
        dp = clip(d + qprod({33'd0, coef[mns_pkg::REG_TIME_STEP]}, v)
                  + qprod({33'd0, coef[mns_pkg::REG_PRED_DISP]}, a));
        vp = clip(v + qprod({33'd0, coef[mns_pkg::REG_PRED_VEL]}, a));
        rhs = clip(force_q[idx] - qprod(xi, vp) - qprod(wsq[idx], dp));
        lhs = clip(64'sd65536 + qprod({33'd0, coef[mns_pkg::REG_GAMMA_DT]}, xi)
                   + qprod({33'd0, coef[mns_pkg::REG_BETA_DT_SQ]}, wsq[idx]));
        if (lhs < 64'sd65536) lhs = 64'sd65536;
        an = clip((rhs * 64'sd65536) / lhs);
        accel[idx] = an;
        vel[idx] = clip(vp + qprod({33'd0, coef[mns_pkg::REG_GAMMA_DT]}, an));
        disp[idx] = clip(dp + qprod({33'd0, coef[mns_pkg::REG_BETA_DT_SQ]}, an));
      end
      exp_idx.push_back(idx);
      exp_d.push_back(disp[idx][31:0]);
      exp_v.push_back(vel[idx][31:0]);
      exp_a.push_back(accel[idx][31:0]);
    endfunction

    function void check_result(logic [mns_pkg::IDX_W-1:0] idx,
                               logic signed [mns_pkg::DW-1:0] d,
                               logic signed [mns_pkg::DW-1:0] v,
                               logic signed [mns_pkg::DW-1:0] a);
      logic [mns_pkg::IDX_W-1:0] ei;
      logic signed [mns_pkg::DW-1:0] ed, ev, ea;
      if (exp_idx.size() == 0) begin
        $error("unexpected result word for mode %0d", idx);
        errors++;
        return;
      end
      ei = exp_idx.pop_front(); ed = exp_d.pop_front();
      ev = exp_v.pop_front(); ea = exp_a.pop_front();
      if (idx !== ei) begin
        $error("mode_index_out: expected %0d, got %0d", ei, idx); errors++;
      end
      if (d !== ed) begin
        $error("displacement: expected %0d, got %0d", ed, d); errors++;
      end
      if (v !== ev) begin
        $error("velocity: expected %0d, got %0d", ev, v); errors++;
      end
      if (a !== ea) begin
        $error("acceleration: expected %0d, got %0d", ea, a); errors++;
      end
    endfunction

    function int pending();
      return exp_idx.size();
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, in_mode;
  logic [mns_pkg::IDX_W-1:0] in_mode_index;
  logic [mns_pkg::CW-1:0] in_omega_sq;
  logic signed [mns_pkg::DW-1:0] in_modal_force;
  logic out_valid, out_stall;
  logic [mns_pkg::IDX_W-1:0] out_mode_index_out;
  logic signed [mns_pkg::DW-1:0] out_displacement, out_velocity, out_acceleration;
  logic cfg_valid, cfg_ready;
  logic [mns_pkg::CFG_AW-1:0] cfg_index;
  logic [mns_pkg::DW-1:0] cfg_wdata;

  newmark_scoreboard sb;
  int cycles;
  bit stall_on;

  modal_newmark_step dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 0; in_valid = 0; in_mode = 0; in_mode_index = 0; in_omega_sq = 0;
    in_modal_force = 0; out_stall = 0; cfg_valid = 0; cfg_index = 0; cfg_wdata = 0;
    stall_on = 1;
  end

  // receiver stall pattern: phases with and without stalling
  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) stall_on <= ~stall_on;
    out_stall <= stall_on && ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_mode_index_out, out_displacement, out_velocity, out_acceleration);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end
  initial cycles = 0;

  task automatic send_word(logic op, logic [mns_pkg::IDX_W-1:0] idx,
                           logic [mns_pkg::CW-1:0] w,
                           logic signed [mns_pkg::DW-1:0] f);
    in_valid <= 1; in_mode <= op; in_mode_index <= idx;
    in_omega_sq <= w; in_modal_force <= f;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, idx, w, f);
  endtask

  task automatic idle_in(int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [mns_pkg::DW-1:0] val);
    cfg_valid <= 1; cfg_index <= idx[mns_pkg::CFG_AW-1:0]; cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_coef(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_config(int kind);
    logic [mns_pkg::DW-1:0] v;
    for (int r = 0; r < 8; r++) begin
      case (kind)
        0: v = 0;
        1: v = 32'hFFFF_FFFF;
        default: v = (r < 5) ? $urandom_range(0, 32'h0002_0000) : $urandom;
      endcase
      write_reg(r, v);
    end
  endtask

  function automatic logic signed [mns_pkg::DW-1:0] rand_force();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sd131072;
    endcase
  endfunction

  task automatic random_phase(int n);
    int burst;
    logic [mns_pkg::CW-1:0] w;
    logic [mns_pkg::IDX_W-1:0] idx;
    while (n > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && n > 0) begin
        w = ($urandom_range(0, 4) == 0) ? mns_pkg::CW'($urandom)
                                       : mns_pkg::CW'($urandom_range(0, 32'h0008_0000));
        idx = ($urandom_range(0, 9) == 0) ? mns_pkg::IDX_W'($urandom)
                                         : mns_pkg::IDX_W'($urandom_range(0, 7));
        send_word($urandom_range(0, 3) != 0 ? mns_pkg::OP_STEP : mns_pkg::OP_LOAD,
                  idx, w, rand_force());
        burst--; n--;
      end
      if ($urandom_range(0, 1)) idle_in($urandom_range(1, 6));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: steps on zero state, extremes of load fields, all registers
    send_word(mns_pkg::OP_STEP, 0, 0, 0);
    send_word(mns_pkg::OP_LOAD, 63, 31'h7FFFFFFF, 32'sh7FFFFFFF);
    send_word(mns_pkg::OP_LOAD, 1, 0, 32'sh80000000);
    send_word(mns_pkg::OP_STEP, 63, 0, 0);
    send_word(mns_pkg::OP_STEP, 1, 0, 0);
    drain();
    random_config(1);
    send_word(mns_pkg::OP_STEP, 63, 31'h2AAAAAAA, 32'sh55555555);
    send_word(mns_pkg::OP_STEP, 1, 0, 0);
    send_word(mns_pkg::OP_LOAD, 2, 31'h00010000, 32'sh00010000);
    send_word(mns_pkg::OP_STEP, 2, 0, 0);
    send_word(mns_pkg::OP_STEP, 2, 0, 0);
    drain();
    write_reg(mns_pkg::REG_TIME_STEP, 32'h0000_0400);
    write_reg(mns_pkg::REG_BETA_DT_SQ, 32'h0000_0010);
    write_reg(mns_pkg::REG_GAMMA_DT, 32'h0000_0200);
    write_reg(mns_pkg::REG_PRED_DISP, 32'h0000_0010);
    write_reg(mns_pkg::REG_PRED_VEL, 32'h0000_0200);
    write_reg(mns_pkg::REG_MASS_DAMP, 32'h0000_0100);
    write_reg(mns_pkg::REG_STIFF_DAMP, 32'h0000_0080);
    write_reg(7, 32'h1234_5678);
    for (int i = 0; i < 6; i++) send_word(mns_pkg::OP_STEP, 2, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      random_config(ph == 5 ? 0 : 2);
      random_phase(155);
      drain();
    end
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

`default_nettype wire

FILE: modal_newmark_step.f
sv/mns_pkg.sv
sv/mns_ram.sv
sv/mns_front.sv
sv/mns_div.sv
sv/mns_back.sv
sv/modal_newmark_step.sv
test/modal_newmark_step_test.sv
